// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the receiver modules.
// Depends on clk and rst_n being visible in the module that expands them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge of clk while reset is released.
`define GRN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge of clk, reset included.
`define GRN_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GRN_ASSERT(lbl, prop, msg)
`define GRN_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/grn_pkg.sv =====
// Types and constants of the Go-Back-N receiver.
// Used by grn_front, grn_queue, grn_back and go_back_n_receiver; no dependencies.
`default_nettype none

package grn_pkg;

    // Input item kinds.
    localparam logic [1:0] MODE_DATA  = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_WINDOW_SIZE = 1'b0;
    localparam logic CFG_ACK_EVERY   = 1'b1;

    localparam logic [7:0] WINDOW_SIZE_RESET = 8'd7;
    localparam logic [7:0] ACK_EVERY_RESET   = 8'd1;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_RNR   = 2'd1,
        KIND_RR    = 2'd2,
        KIND_REPLY = 2'd3
    } kind_t;

    // The results caused by one request: one always, a second when 'two' is set.
    typedef struct packed {
        logic        two;
        kind_t       kind0;
        logic [7:0]  value0;
        kind_t       kind1;
        logic [7:0]  value1;
    } grn_rec_t;

endpackage

`default_nettype wire

// ===== hdl/grn_front.sv =====
// Front part of the receiver: configuration registers, protocol state and
// classification of each request into a record of results. Depends on grn_pkg.
`default_nettype none

module grn_front
    import grn_pkg::*;
#(
    parameter int SEQ_MODULUS = 8,
    parameter int OCC_BITS    = 9
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       accept,
    input  wire logic [1:0] mode,
    input  wire logic [2:0] seq_num,
    input  wire logic       lost,
    output grn_rec_t        rec,
    output logic            rec_valid
);

    localparam int SEQ_BITS = (SEQ_MODULUS > 2) ? $clog2(SEQ_MODULUS) : 1;
    localparam logic [SEQ_BITS-1:0] SEQ_LAST = SEQ_BITS'(SEQ_MODULUS - 1);

    logic [7:0]          window_size_reg, window_size_next;
    logic [7:0]          ack_every_reg, ack_every_next;
    logic [SEQ_BITS-1:0] expected_reg, expected_next;
    logic [7:0]          frames_reg, frames_next;
    logic [OCC_BITS-1:0] occ_reg, occ_next;
    logic                not_ready_reg, not_ready_next;

    logic [SEQ_BITS-1:0] expected_adv;
    logic [7:0]          expected_val;
    logic [7:0]          frames_inc;
    logic [OCC_BITS-1:0] occ_inc;
    logic [OCC_BITS-1:0] occ_dec;
    logic                buf_full;
    logic                in_order;
    logic                raise_rnr;
    logic                send_ack;
    logic [7:0]          ack_val;

    assign expected_adv = (expected_reg == SEQ_LAST) ? '0 : expected_reg + 1'b1;
    assign expected_val = 8'(expected_reg);
    assign frames_inc   = (&frames_reg) ? frames_reg : frames_reg + 8'd1;
    assign occ_inc      = (&occ_reg) ? occ_reg : occ_reg + 1'b1;
    assign occ_dec      = occ_reg - 1'b1;
    assign buf_full     = occ_reg >= OCC_BITS'(window_size_reg);
    assign in_order     = 8'(seq_num) == expected_val;
    assign raise_rnr    = buf_full && !not_ready_reg;

    always_comb
    begin
        window_size_next = window_size_reg;
        ack_every_next   = ack_every_reg;
        expected_next    = expected_reg;
        frames_next      = frames_reg;
        occ_next         = occ_reg;
        not_ready_next   = not_ready_reg;
        rec              = '0;
        rec_valid        = 1'b0;
        send_ack         = 1'b0;
        ack_val          = expected_val;

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_WINDOW_SIZE: window_size_next = cfg_data;
                CFG_ACK_EVERY:   ack_every_next   = cfg_data;
                default:         ;
            endcase
        end

        if (accept)
        begin
            case (mode)
                MODE_QUERY:
                begin
                    rec.kind0  = KIND_REPLY;
                    rec.value0 = window_size_reg;
                    rec_valid  = 1'b1;
                end
                MODE_TICK:
                begin
                    if (occ_reg != '0)
                    begin
                        occ_next = occ_dec;
                        if (not_ready_reg && (occ_dec < OCC_BITS'(window_size_reg)))
                        begin
                            not_ready_next = 1'b0;
                            rec.kind0      = KIND_RR;
                            rec.value0     = expected_val;
                            rec_valid      = 1'b1;
                        end
                    end
                end
                MODE_DATA:
                begin
                    if (raise_rnr)
                    begin
                        not_ready_next = 1'b1;
                    end
                    if (!lost)
                    begin
                        if (in_order)
                        begin
                            occ_next      = occ_inc;
                            expected_next = expected_adv;
                            if (frames_inc >= ack_every_reg)
                            begin
                                send_ack    = 1'b1;
                                ack_val     = 8'(expected_adv);
                                frames_next = 8'd0;
                            end
                            else
                            begin
                                frames_next = frames_inc;
                            end
                        end
                        else
                        begin
                            // Out of order: repeat the acknowledgement of the
                            // expected number and restart the count.
                            send_ack    = 1'b1;
                            frames_next = 8'd0;
                        end
                    end
                    if (raise_rnr)
                    begin
                        rec.kind0  = KIND_RNR;
                        rec.value0 = expected_val;
                        rec.two    = send_ack;
                        rec.kind1  = KIND_ACK;
                        rec.value1 = ack_val;
                        rec_valid  = 1'b1;
                    end
                    else if (send_ack)
                    begin
                        rec.kind0  = KIND_ACK;
                        rec.value0 = ack_val;
                        rec_valid  = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_SIZE_RESET;
            ack_every_reg   <= ACK_EVERY_RESET;
            expected_reg    <= '0;
            frames_reg      <= '0;
            occ_reg         <= '0;
            not_ready_reg   <= 1'b0;
        end
        else
        begin
            window_size_reg <= window_size_next;
            ack_every_reg   <= ack_every_next;
            expected_reg    <= expected_next;
            frames_reg      <= frames_next;
            occ_reg         <= occ_next;
            not_ready_reg   <= not_ready_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/grn_queue.sv =====
// Short queue of result records between the front and back parts.
// Depends on grn_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module grn_queue
    import grn_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     wr_en,
    input  wire grn_rec_t wr_rec,
    input  wire logic     rd_en,
    output grn_rec_t      rd_rec,
    output logic          not_empty,
    output logic          full
);

    grn_rec_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [QUEUE_PTR_BITS-1:0] ptr_gap;

    assign full      = cnt_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign rd_rec    = entry_reg[rd_ptr_reg];
    assign ptr_gap   = wr_ptr_reg - rd_ptr_reg;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `GRN_ASSERT(a_no_write_when_full, wr_en |-> !full, "queue written while full")
    `GRN_ASSERT(a_no_read_when_empty, rd_en |-> not_empty, "queue read while empty")
    `GRN_ASSERT(a_cnt_tracks_ptrs, !full |-> (ptr_gap == QUEUE_PTR_BITS'(cnt_reg)), "queue count off")

endmodule

`default_nettype wire

// ===== hdl/grn_back.sv =====
// Back part of the receiver: takes records from the queue and hands their
// results out one at a time on the result port. Depends on grn_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module grn_back
    import grn_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       q_valid,
    input  wire grn_rec_t   q_rec,
    output logic            q_pop,
    input  wire logic       pop,
    output logic            empty,
    output logic [1:0]      kind,
    output logic [7:0]      value,
    output logic            last
);

    grn_rec_t rec_reg;
    logic     valid_reg, valid_next;
    logic     phase_reg, phase_next;
    logic     taken;
    logic     finish;

    assign empty  = !valid_reg;
    assign last   = phase_reg || !rec_reg.two;
    assign kind   = phase_reg ? rec_reg.kind1 : rec_reg.kind0;
    assign value  = phase_reg ? rec_reg.value1 : rec_reg.value0;
    assign taken  = pop && valid_reg;
    assign finish = taken && last;
    assign q_pop  = q_valid && (!valid_reg || finish);

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (q_pop)
        begin
            valid_next = 1'b1;
            phase_next = 1'b0;
        end
        else if (finish)
        begin
            valid_next = 1'b0;
            phase_next = 1'b0;
        end
        else if (taken)
        begin
            phase_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rec_reg <= q_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    `GRN_ASSERT(a_phase_needs_pair, phase_reg |-> (valid_reg && rec_reg.two), "second result shown without a pair")
    `GRN_ASSERT(a_second_follows, (taken && !last) |=> (!empty && last), "second result of a pair not shown next")
    `GRN_ASSERT(a_drains, (finish && !q_valid) |=> empty, "result port not empty after last result taken")

endmodule

`default_nettype wire

// ===== hdl/go_back_n_receiver.sv =====
// Go-Back-N receiver: top level joining the front part, the record queue and the back part.
// Depends on grn_pkg, grn_front, grn_queue and grn_back.
`default_nettype none

// Path: an accepted request's record is written into the queue, and the back part
// then loads it into its record register, which drives the result ports.
// Throughput: one request per cycle while the queue is not full; a data frame that
// raises RNR and also acknowledges causes two results, which the back part hands out
// through the single result port one per cycle while pop is asserted.
// Reset (rst_n, asynchronous, active low) clears all protocol state and the queue,
// and sets window_size to 7 and ack_every to 1.

module go_back_n_receiver
    import grn_pkg::*;
#(
    parameter int SEQ_MODULUS = 8,
    parameter int OCC_BITS    = 9
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       push,
    output logic            full,
    input  wire logic [1:0] mode,
    input  wire logic [2:0] seq_num,
    input  wire logic       lost,
    output logic            empty,
    input  wire logic       pop,
    output logic [1:0]      kind,
    output logic [7:0]      value,
    output logic            last
);

    // A request is taken whenever the queue has room. The front part updates
    // its state in the same edge and, if the request causes any result, writes
    // one record holding up to two results into the queue.
    logic     accept;
    grn_rec_t front_rec;
    logic     front_rec_valid;
    grn_rec_t head_rec;
    logic     head_valid;
    logic     head_pop;

    assign accept = push && !full;

    grn_front #(
        .SEQ_MODULUS (SEQ_MODULUS),
        .OCC_BITS    (OCC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .mode      (mode),
        .seq_num   (seq_num),
        .lost      (lost),
        .rec       (front_rec),
        .rec_valid (front_rec_valid)
    );

    // The queue lets the front keep taking requests while results wait on the
    // result port, and lets the back drain while no requests arrive.
    grn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (front_rec_valid),
        .wr_rec    (front_rec),
        .rd_en     (head_pop),
        .rd_rec    (head_rec),
        .not_empty (head_valid),
        .full      (full)
    );

    // The back part holds the record being shown and steps through its
    // results; it fetches the next record in the cycle the last one is taken.
    grn_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (head_valid),
        .q_rec   (head_rec),
        .q_pop   (head_pop),
        .pop     (pop),
        .empty   (empty),
        .kind    (kind),
        .value   (value),
        .last    (last)
    );

endmodule

`default_nettype wire
